// ----- hdl/sed_pkg.sv -----
// Shared types and constants of the speech endpoint detector.
package sed_pkg;

	localparam int OUT_W         = 24;
	localparam int POS_WIDTH_DEF = 24;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;
	localparam int ENERGY_W      = 32;
	localparam int ZCR_W         = 16;
	localparam int COUNT_W       = 16;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	typedef enum logic [1:0] {
		MODE_SILENT  = 2'd0,
		MODE_INTERIM = 2'd1,
		MODE_VOICE   = 2'd2,
		MODE_OVER    = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_HIGH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_LOW       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZCR_LOW          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_FLOOR     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZCR_FLOOR        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SILENCE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VOICE_LENGTH = 3'd6;

	localparam logic [ENERGY_W-1:0] RST_ENERGY_HIGH      = 32'd2560;
	localparam logic [ENERGY_W-1:0] RST_ENERGY_LOW       = 32'd512;
	localparam logic [ZCR_W-1:0]    RST_ZCR_LOW          = 16'd1280;
	localparam logic [ENERGY_W-1:0] RST_ENERGY_FLOOR     = 32'd0;
	localparam logic [ZCR_W-1:0]    RST_ZCR_FLOOR        = 16'd0;
	localparam logic [COUNT_W-1:0]  RST_MIN_SILENCE      = 16'd10;
	localparam logic [COUNT_W-1:0]  RST_MIN_VOICE_LENGTH = 16'd15;

endpackage

// ----- hdl/speech_endpoint_detector.sv -----
// Dual-threshold speech endpoint detector, top level.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | energy, zcr, last_item
//  output   | out_valid/ out_ready | seg_valid, seg_begin, seg_end,
//           |                      | seg_length, stream_done
//  config   | cfg_we               | cfg_index, cfg_data
//
// One request per cycle while the result is not stalled; each request passes
// through the input register and then lands in the result register.
// The segment state machine and its counters update as a request moves from
// the input register into the result register.
// Reset clears the state machine, counters and both pipeline valids, and loads
// the threshold register defaults. A stalled result holds the pipeline; the
// input register still takes one more request while the result waits, if empty.
module speech_endpoint_detector
	import sed_pkg::*;
#(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ENERGY_W-1:0]   energy,
	input  logic [ZCR_W-1:0]      zcr,
	input  logic                  last_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  seg_valid,
	output logic [OUT_W-1:0]      seg_begin,
	output logic [OUT_W-1:0]      seg_end,
	output logic [OUT_W-1:0]      seg_length,
	output logic                  stream_done
);

	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
	localparam int WW = (POS_WIDTH > OUT_W) ? POS_WIDTH : OUT_W;

	function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
		return (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [POS_WIDTH-1:0] sat_add(input logic [POS_WIDTH-1:0] a,
			input logic [POS_WIDTH-1:0] b);
		logic [POS_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[POS_WIDTH] ? POS_MAX : s[POS_WIDTH-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] out_sat(input logic [POS_WIDTH-1:0] v);
		logic [WW-1:0] x;
		x = WW'(v);
		return (x > WW'(OUT_MAX)) ? OUT_MAX : x[OUT_W-1:0];
	endfunction

	// threshold registers
	logic [ENERGY_W-1:0] energy_high_q, energy_low_q, energy_floor_q;
	logic [ZCR_W-1:0]    zcr_low_q, zcr_floor_q;
	logic [COUNT_W-1:0]  min_silence_q, min_voice_length_q;

	// input stage
	logic                valid_s1;
	logic [ENERGY_W-1:0] energy_s1;
	logic [ZCR_W-1:0]    zcr_s1;
	logic                last_s1;

	// result stage
	logic                valid_s2;
	logic                seg_valid_s2;
	logic [OUT_W-1:0]    begin_s2, end_s2, length_s2;
	logic                done_s2;

	// segment state
	mode_t               mode_q, mode_d;
	logic [POS_WIDTH-1:0] position_q, seg_start_q, seg_stop_q, voice_len_q, silence_len_q;
	logic [POS_WIDTH-1:0] seg_start_d, seg_stop_d, voice_len_d, silence_len_d;
	logic                found_q, found_d;

	logic                adv, step;
	logic [POS_WIDTH-1:0] back, voice_inc, silence_inc;

	logic                res_valid;
	logic [POS_WIDTH-1:0] res_begin, res_end, res_len;

	assign adv      = !valid_s2 || out_ready;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_high_q      <= RST_ENERGY_HIGH;
			energy_low_q       <= RST_ENERGY_LOW;
			zcr_low_q          <= RST_ZCR_LOW;
			energy_floor_q     <= RST_ENERGY_FLOOR;
			zcr_floor_q        <= RST_ZCR_FLOOR;
			min_silence_q      <= RST_MIN_SILENCE;
			min_voice_length_q <= RST_MIN_VOICE_LENGTH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENERGY_HIGH:      energy_high_q      <= cfg_data;
				REG_ENERGY_LOW:       energy_low_q       <= cfg_data;
				REG_ZCR_LOW:          zcr_low_q          <= cfg_data[ZCR_W-1:0];
				REG_ENERGY_FLOOR:     energy_floor_q     <= cfg_data;
				REG_ZCR_FLOOR:        zcr_floor_q        <= cfg_data[ZCR_W-1:0];
				REG_MIN_SILENCE:      min_silence_q      <= cfg_data[COUNT_W-1:0];
				REG_MIN_VOICE_LENGTH: min_voice_length_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			energy_s1 <= energy;
			zcr_s1    <= zcr;
			last_s1   <= last_item;
		end
	end

	// next state
	always_comb begin
		mode_d        = mode_q;
		seg_start_d   = seg_start_q;
		seg_stop_d    = seg_stop_q;
		voice_len_d   = voice_len_q;
		silence_len_d = silence_len_q;
		found_d       = found_q;
		voice_inc     = sat_inc(voice_len_q);
		silence_inc   = sat_inc(silence_len_q);
		back          = voice_inc;
		case (mode_q)
			MODE_SILENT, MODE_INTERIM: begin
				if (energy_s1 > energy_high_q) begin
					seg_start_d   = (position_q >= back) ? position_q - back : '0;
					mode_d        = MODE_VOICE;
					voice_len_d   = voice_inc;
					silence_len_d = '0;
				end else if (energy_s1 > energy_low_q || zcr_s1 > zcr_low_q) begin
					mode_d      = MODE_INTERIM;
					voice_len_d = voice_inc;
				end else begin
					mode_d      = MODE_SILENT;
					voice_len_d = '0;
				end
			end
			MODE_VOICE: begin
				if (energy_s1 > energy_floor_q || zcr_s1 > zcr_floor_q) begin
					voice_len_d = voice_inc;
				end else begin
					silence_len_d = silence_inc;
					if (silence_inc < POS_WIDTH'(min_silence_q)) begin
						voice_len_d = voice_inc;
					end else if (voice_len_q < POS_WIDTH'(min_voice_length_q)) begin
						mode_d        = MODE_SILENT;
						silence_len_d = '0;
						voice_len_d   = '0;
					end else begin
						mode_d     = MODE_OVER;
						seg_stop_d = sat_add(seg_start_q, voice_len_q);
					end
				end
			end
			MODE_OVER: begin
				voice_len_d = '0;
				found_d     = 1'b1;
				mode_d      = MODE_SILENT;
			end
			default: mode_d = MODE_SILENT;
		endcase
	end

	// result
	always_comb begin
		res_valid = 1'b0;
		res_begin = '0;
		res_end   = '0;
		res_len   = '0;
		if (mode_q == MODE_OVER) begin
			res_valid = 1'b1;
			res_begin = seg_start_q;
			res_end   = seg_stop_q;
			res_len   = voice_len_q;
		end else if (last_s1) begin
			case (mode_d)
				MODE_VOICE: begin
					res_valid = 1'b1;
					res_begin = seg_start_d;
					res_end   = sat_add(seg_start_d, voice_len_d);
					res_len   = voice_len_d;
				end
				MODE_OVER: begin
					res_valid = 1'b1;
					res_begin = seg_start_d;
					res_end   = seg_stop_d;
					res_len   = voice_len_d;
				end
				default: begin
					if (!found_q) begin
						res_valid = 1'b1;
						res_end   = voice_len_d;
						res_len   = voice_len_d;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_SILENT;
			position_q    <= '0;
			seg_start_q   <= '0;
			seg_stop_q    <= '0;
			voice_len_q   <= '0;
			silence_len_q <= '0;
			found_q       <= 1'b0;
		end else if (step) begin
			if (last_s1) begin
				mode_q        <= MODE_SILENT;
				position_q    <= '0;
				seg_start_q   <= '0;
				seg_stop_q    <= '0;
				voice_len_q   <= '0;
				silence_len_q <= '0;
				found_q       <= 1'b0;
			end else begin
				mode_q        <= mode_d;
				position_q    <= sat_inc(position_q);
				seg_start_q   <= seg_start_d;
				seg_stop_q    <= seg_stop_d;
				voice_len_q   <= voice_len_d;
				silence_len_q <= silence_len_d;
				found_q       <= found_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			seg_valid_s2 <= res_valid;
			begin_s2     <= out_sat(res_begin);
			end_s2       <= out_sat(res_end);
			length_s2    <= out_sat(res_len);
			done_s2      <= last_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign seg_valid   = seg_valid_s2;
	assign seg_begin   = begin_s2;
	assign seg_end     = end_s2;
	assign seg_length  = length_s2;
	assign stream_done = done_s2;

endmodule

// ----- hdl/sed_checker.sv -----
// Port-level checks of the speech endpoint detector, bound to the top level.
module sed_checker
	import sed_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic             seg_valid,
	input logic [OUT_W-1:0] seg_begin,
	input logic [OUT_W-1:0] seg_end,
	input logic [OUT_W-1:0] seg_length,
	input logic             stream_done
);

	// empty results carry zero fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seg_valid |-> seg_begin == '0 && seg_end == '0 && seg_length == '0)
		else $error("empty result with nonzero fields");

	a_end_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seg_valid |-> seg_end >= seg_begin)
		else $error("segment end before begin");

	// unsaturated end is begin plus length
	a_end_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seg_valid && seg_end != OUT_MAX
			|-> {1'b0, seg_end} == {1'b0, seg_begin} + {1'b0, seg_length})
		else $error("segment end mismatch");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(seg_valid) && $stable(seg_begin)
			&& $stable(seg_end) && $stable(seg_length) && $stable(stream_done))
		else $error("stalled result changed");

endmodule

bind speech_endpoint_detector sed_checker u_sed_checker (.*);
